### hw/rtl/drc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// drc_pkg
// Shared types, constants and helpers for the dirty rectangle coalescer.
// ============================================================================
package drc_pkg;

    // Field widths.
    localparam int IN_W      = 16;
    localparam int POS_W     = 12;
    localparam int DIM_W     = 13;
    localparam int AREA_W    = 25;
    localparam int PROD_W    = 2 * DIM_W;
    localparam int TOTAL_W   = 31;
    localparam int RECT_W    = 2 * POS_W + 2 * DIM_W;

    // Default list depth.
    localparam int MAX_RECTS_DEF = 48;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_HEIGHT = 1'd1;

    // Register reset values and the largest usable framebuffer dimension.
    localparam logic [DIM_W-1:0] FB_W_RST = 13'd1920;
    localparam logic [DIM_W-1:0] FB_H_RST = 13'd1080;
    localparam logic [DIM_W-1:0] DIM_MAX  = 13'd4096;
    localparam logic [DIM_W-1:0] DIM_MIN  = 13'd1;

    // One stored rectangle: clipped, so it always lies on screen.
    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } rect_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // capture an input item, clear scan index and total
        logic clip_ld;    // load the clipped rectangle
        logic area_ld;    // load the area of the clipped rectangle
        logic rd_en;      // read the list memory
        logic rd_last;    // read address is the last stored entry
        logic rect_ld;    // capture the entry read and its union
        logic prod_ld;    // register entry area and union area
        logic merge;      // union replaces the incoming rectangle
        logic move_wr;    // last entry moves into the freed slot
        logic step;       // advance the scan index
        logic fin_wr;     // store the survivor or collapse to full screen
        logic out_empty;  // present the empty-list item
        logic out_rect;   // present the current entry as an item
    } drc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic drop;       // clipped rectangle is empty
        logic i_lt_cnt;   // scan index below the entry count
        logic cnt_zero;   // list holds no entries
        logic merge_ok;   // union area is no larger than the sum of the two areas
        logic f_last;     // scan index is the last entry
        logic out_busy;   // output register holds an item not yet taken
    } drc_status_t;

    // A zero size acts as one and anything above 4096 acts as 4096.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_MIN;
        else if (v > DIM_MAX)
            r = DIM_MAX;
        else
            r = v;
        return r;
    endfunction

endpackage

### hw/rtl/drc_if.sv
`timescale 1ns / 1ps
// ============================================================================
// drc_in_if / drc_out_if
// Valid/ready channels for input items and result items.
// ============================================================================
interface drc_in_if
    import drc_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   func;
    logic signed [IN_W-1:0] rect_x;
    logic signed [IN_W-1:0] rect_y;
    logic signed [IN_W-1:0] rect_w;
    logic signed [IN_W-1:0] rect_h;

    modport source (output valid, func, rect_x, rect_y, rect_w, rect_h, input ready);
    modport sink   (input valid, func, rect_x, rect_y, rect_w, rect_h, output ready);
endinterface

interface drc_out_if
    import drc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [POS_W-1:0]     out_x;
    logic [POS_W-1:0]     out_y;
    logic [DIM_W-1:0]     out_w;
    logic [DIM_W-1:0]     out_h;
    logic [TOTAL_W-1:0]   total_area;
    logic                 is_last;
    logic                 list_empty;

    modport source (output valid, out_x, out_y, out_w, out_h, total_area, is_last,
                    list_empty, input ready);
    modport sink   (input valid, out_x, out_y, out_w, out_h, total_area, is_last,
                    list_empty, output ready);
endinterface

### hw/rtl/drc_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// drc_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module drc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/drc_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// drc_datapath
// Clipping, union and area arithmetic, list memory, counters and output item.
// ============================================================================
module drc_datapath
    import drc_pkg::*;
#(
    parameter int MAX_RECTS = MAX_RECTS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    // Configuration writes.
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_idx,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    // Input payload.
    input  logic signed [IN_W-1:0]  rect_x,
    input  logic signed [IN_W-1:0]  rect_y,
    input  logic signed [IN_W-1:0]  rect_w,
    input  logic signed [IN_W-1:0]  rect_h,
    // Output item.
    input  logic                    out_ready,
    output logic                    out_valid,
    output logic [POS_W-1:0]        out_x,
    output logic [POS_W-1:0]        out_y,
    output logic [DIM_W-1:0]        out_w,
    output logic [DIM_W-1:0]        out_h,
    output logic [TOTAL_W-1:0]      total_area,
    output logic                    is_last,
    output logic                    list_empty,
    // Controller link.
    input  drc_cmd_t                cmd,
    output drc_status_t             status
);

    localparam int IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CNT_W = $clog2(MAX_RECTS + 1);
    localparam int EXT_W = IN_W + 1;

    // Configuration registers.
    logic [DIM_W-1:0] fb_w_reg, fb_h_reg;
    logic [DIM_W-1:0] eff_w, eff_h;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_w_reg <= FB_W_RST;
            fb_h_reg <= FB_H_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_FB_WIDTH:  fb_w_reg <= cfg_data;
                CFG_FB_HEIGHT: fb_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign eff_w = eff_dim(fb_w_reg);
    assign eff_h = eff_dim(fb_h_reg);

    // Clip stage: edges clamped to the screen, registered on accept.
    logic signed [EXT_W-1:0] xs, ys, xe, ye, lim_w, lim_h;
    logic signed [EXT_W-1:0] x0_next, y0_next, x1_next, y1_next;
    logic signed [EXT_W-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic                    nil_next, nil_reg;

    always_comb
    begin
        xs      = {rect_x[IN_W-1], rect_x};
        ys      = {rect_y[IN_W-1], rect_y};
        xe      = xs + {rect_w[IN_W-1], rect_w};
        ye      = ys + {rect_h[IN_W-1], rect_h};
        lim_w   = {{(EXT_W-DIM_W){1'b0}}, eff_w};
        lim_h   = {{(EXT_W-DIM_W){1'b0}}, eff_h};
        x0_next = xs[EXT_W-1] ? '0 : xs;
        y0_next = ys[EXT_W-1] ? '0 : ys;
        x1_next = (xe > lim_w) ? lim_w : xe;
        y1_next = (ye > lim_h) ? lim_h : ye;
        nil_next = rect_w[IN_W-1] || (rect_w == '0) || rect_h[IN_W-1] || (rect_h == '0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            x0_reg  <= x0_next;
            y0_reg  <= y0_next;
            x1_reg  <= x1_next;
            y1_reg  <= y1_next;
            nil_reg <= nil_next;
        end
    end

    assign status.drop = nil_reg || (x1_reg <= x0_reg) || (y1_reg <= y0_reg);

    // Incoming rectangle and its area.
    rect_t             cur_reg;
    logic [AREA_W-1:0] cur_area_reg;
    logic [PROD_W-1:0] cur_prod;
    logic [EXT_W-1:0]  cur_w_diff, cur_h_diff;

    assign cur_w_diff = x1_reg - x0_reg;
    assign cur_h_diff = y1_reg - y0_reg;
    assign cur_prod   = cur_reg.w * cur_reg.h;

    // List memory.
    rect_t            rd_rect;
    logic [RECT_W-1:0] rd_data;
    logic [RECT_W-1:0] wr_data;
    logic [IDX_W-1:0]  wr_addr, rd_addr;
    logic              wr_en;
    logic [CNT_W-1:0]  cnt_reg, i_reg;
    logic              cnt_full;
    rect_t             full_rect;

    assign rd_rect  = rect_t'(rd_data);
    assign cnt_full = (cnt_reg >= CNT_W'(MAX_RECTS));

    always_comb
    begin
        full_rect.x = '0;
        full_rect.y = '0;
        full_rect.w = eff_w;
        full_rect.h = eff_h;
    end

    always_comb
    begin
        wr_en   = cmd.move_wr || cmd.fin_wr;
        wr_addr = i_reg[IDX_W-1:0];
        wr_data = rd_data;
        if (cmd.fin_wr)
        begin
            wr_addr = cnt_full ? '0 : cnt_reg[IDX_W-1:0];
            wr_data = cnt_full ? RECT_W'(full_rect) : RECT_W'(cur_reg);
        end
    end

    logic [CNT_W-1:0] cnt_m1;
    assign cnt_m1  = cnt_reg - CNT_W'(1);
    assign rd_addr = cmd.rd_last ? cnt_m1[IDX_W-1:0] : i_reg[IDX_W-1:0];

    drc_ram #(
        .WIDTH (RECT_W),
        .DEPTH (MAX_RECTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Stored entry and bounding union with the incoming rectangle.
    rect_t              t_reg, u_reg, u_next;
    logic [POS_W-1:0]   ul, ut;
    logic [DIM_W:0]     ar, br, ab, bb, ur, ub;

    always_comb
    begin
        ul = (rd_rect.x < cur_reg.x) ? rd_rect.x : cur_reg.x;
        ut = (rd_rect.y < cur_reg.y) ? rd_rect.y : cur_reg.y;
        ar = {2'b00, rd_rect.x} + {1'b0, rd_rect.w};
        br = {2'b00, cur_reg.x} + {1'b0, cur_reg.w};
        ab = {2'b00, rd_rect.y} + {1'b0, rd_rect.h};
        bb = {2'b00, cur_reg.y} + {1'b0, cur_reg.h};
        ur = (ar > br) ? ar : br;
        ub = (ab > bb) ? ab : bb;
        u_next.x = ul;
        u_next.y = ut;
        u_next.w = DIM_W'(ur - {2'b00, ul});
        u_next.h = DIM_W'(ub - {2'b00, ut});
    end

    // Area products, one register after each multiplier.
    logic [AREA_W-1:0] area_t_reg, area_u_reg;
    logic [PROD_W-1:0] t_prod, u_prod;
    logic [AREA_W:0]   area_sum;

    assign t_prod   = t_reg.w * t_reg.h;
    assign u_prod   = u_reg.w * u_reg.h;
    assign area_sum = {1'b0, area_t_reg} + {1'b0, cur_area_reg};

    assign status.merge_ok = ({1'b0, area_u_reg} <= area_sum);

    always_ff @(posedge clk)
    begin
        if (cmd.clip_ld)
        begin
            cur_reg.x <= x0_reg[POS_W-1:0];
            cur_reg.y <= y0_reg[POS_W-1:0];
            cur_reg.w <= cur_w_diff[DIM_W-1:0];
            cur_reg.h <= cur_h_diff[DIM_W-1:0];
        end
        else if (cmd.merge)
        begin
            cur_reg <= u_reg;
        end
        if (cmd.area_ld)
            cur_area_reg <= cur_prod[AREA_W-1:0];
        else if (cmd.merge)
            cur_area_reg <= area_u_reg;
        if (cmd.rect_ld)
        begin
            t_reg <= rd_rect;
            u_reg <= u_next;
        end
        if (cmd.prod_ld)
        begin
            area_t_reg <= t_prod[AREA_W-1:0];
            area_u_reg <= u_prod[AREA_W-1:0];
        end
    end

    // Entry count, scan index and running total.
    logic [TOTAL_W-1:0] total_reg, total_next;
    assign total_next = total_reg + {{(TOTAL_W-AREA_W){1'b0}}, area_t_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            i_reg     <= '0;
            total_reg <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                i_reg     <= '0;
                total_reg <= '0;
            end
            if (cmd.clip_ld || cmd.move_wr)
                i_reg <= '0;
            if (cmd.step)
                i_reg <= i_reg + CNT_W'(1);
            if (cmd.merge)
                cnt_reg <= cnt_m1;
            if (cmd.fin_wr)
                cnt_reg <= cnt_full ? CNT_W'(1) : cnt_reg + CNT_W'(1);
            if (cmd.out_rect)
            begin
                i_reg     <= i_reg + CNT_W'(1);
                total_reg <= total_next;
                if (status.f_last)
                    cnt_reg <= '0;
            end
            if (cmd.out_empty)
                cnt_reg <= '0;
        end
    end

    assign status.i_lt_cnt = (i_reg < cnt_reg);
    assign status.cnt_zero = (cnt_reg == '0);
    assign status.f_last   = ((i_reg + CNT_W'(1)) == cnt_reg);

    // Output item register.
    logic               out_valid_reg;
    rect_t              out_rect_reg;
    logic [TOTAL_W-1:0] out_total_reg;
    logic               out_last_reg, out_empty_reg;

    assign status.out_busy = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_rect || cmd.out_empty)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_rect)
        begin
            out_rect_reg  <= t_reg;
            out_total_reg <= status.f_last ? total_next : '0;
            out_last_reg  <= status.f_last;
            out_empty_reg <= 1'b0;
        end
        else if (cmd.out_empty)
        begin
            out_rect_reg  <= '0;
            out_total_reg <= '0;
            out_last_reg  <= 1'b1;
            out_empty_reg <= 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_x      = out_rect_reg.x;
    assign out_y      = out_rect_reg.y;
    assign out_w      = out_rect_reg.w;
    assign out_h      = out_rect_reg.h;
    assign total_area = out_total_reg;
    assign is_last    = out_last_reg;
    assign list_empty = out_empty_reg;

endmodule

### hw/rtl/drc_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// drc_ctrl
// Sequencer for append scans, merges and flush output.
// ============================================================================
module drc_ctrl
    import drc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_func,
    output logic        in_ready,
    input  drc_status_t status,
    output drc_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLIP  = 4'd1;
    localparam logic [3:0] S_AREA  = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_UNION = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_CMP   = 4'd6;
    localparam logic [3:0] S_MOVE  = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;
    localparam logic [3:0] S_F_RD  = 4'd9;
    localparam logic [3:0] S_F_LD  = 4'd10;
    localparam logic [3:0] S_F_MUL = 4'd11;
    localparam logic [3:0] S_F_OUT = 4'd12;

    localparam logic FUNC_FLUSH = 1'b1;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = (in_func == FUNC_FLUSH) ? S_F_RD : S_CLIP;
                end
            end
            S_CLIP:
            begin
                if (status.drop)
                    state_next = S_IDLE;
                else
                begin
                    cmd.clip_ld = 1'b1;
                    state_next  = S_AREA;
                end
            end
            S_AREA:
            begin
                cmd.area_ld = 1'b1;
                state_next  = S_RD;
            end
            S_RD:
            begin
                if (status.i_lt_cnt)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_UNION;
                end
                else
                    state_next = S_FIN;
            end
            S_UNION:
            begin
                cmd.rect_ld = 1'b1;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                cmd.prod_ld = 1'b1;
                state_next  = S_CMP;
            end
            S_CMP:
            begin
                if (status.merge_ok)
                begin
                    // Drop the entry and fetch the last one to fill its slot.
                    cmd.merge   = 1'b1;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_last = 1'b1;
                    state_next  = S_MOVE;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_RD;
                end
            end
            S_MOVE:
            begin
                cmd.move_wr = 1'b1;
                state_next  = S_RD;
            end
            S_FIN:
            begin
                cmd.fin_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_F_RD:
            begin
                if (status.cnt_zero)
                begin
                    if (!status.out_busy)
                    begin
                        cmd.out_empty = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_F_LD;
                end
            end
            S_F_LD:
            begin
                cmd.rect_ld = 1'b1;
                state_next  = S_F_MUL;
            end
            S_F_MUL:
            begin
                cmd.prod_ld = 1'b1;
                state_next  = S_F_OUT;
            end
            S_F_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_rect = 1'b1;
                    state_next   = status.f_last ? S_IDLE : S_F_RD;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

### hw/rtl/dirty_rect_coalescer_top.sv
`timescale 1ns / 1ps
// ============================================================================
// dirty_rect_coalescer_top
// Bounded dirty rectangle list with merge-on-append and flush output.
// ============================================================================
// One item is worked on at a time; the input is ready only while the block is
// idle. An append is accepted and clipped, then every stored entry it scans
// goes through memory read, union, area multiply and compare; each merge also
// moves the last entry into the freed slot and restarts the scan at entry
// zero, and the scan ends by storing the result. A clipped-away append returns
// to idle after the clip. A flush reads, captures, multiplies and outputs each
// stored rectangle in turn and waits whenever the output is not ready; an
// empty flush presents only the empty-list item. These steps follow from the
// single read port of the list memory and the registered area multiply. The
// list memory needs no clearing after reset.
module dirty_rect_coalescer_top
    import drc_pkg::*;
#(
    parameter int MAX_RECTS = MAX_RECTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    drc_in_if.sink                in_ch,
    drc_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    drc_cmd_t    cmd;
    drc_status_t status;

    // Sequencer.
    drc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_func  (in_ch.func),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic, list storage and output register.
    drc_datapath #(
        .MAX_RECTS (MAX_RECTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data),
        .rect_x     (in_ch.rect_x),
        .rect_y     (in_ch.rect_y),
        .rect_w     (in_ch.rect_w),
        .rect_h     (in_ch.rect_h),
        .out_ready  (out_ch.ready),
        .out_valid  (out_ch.valid),
        .out_x      (out_ch.out_x),
        .out_y      (out_ch.out_y),
        .out_w      (out_ch.out_w),
        .out_h      (out_ch.out_h),
        .total_area (out_ch.total_area),
        .is_last    (out_ch.is_last),
        .list_empty (out_ch.list_empty),
        .cmd        (cmd),
        .status     (status)
    );

endmodule

### hw/rtl/drc_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// drc_prop_checker
// Port-level checks on the coalescer's result items.
// ============================================================================
module drc_prop_checker
    import drc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [POS_W-1:0]   out_x,
    input logic [POS_W-1:0]   out_y,
    input logic [DIM_W-1:0]   out_w,
    input logic [DIM_W-1:0]   out_h,
    input logic [TOTAL_W-1:0] total_area,
    input logic               is_last,
    input logic               list_empty
);

    // An empty-list item is the last one and carries no geometry or area.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && list_empty |-> is_last && out_x == '0 && out_y == '0 &&
            out_w == '0 && out_h == '0 && total_area == '0)
    else $error("empty-list item carries data");

    // The total is reported on the last item only.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_last |-> total_area == '0)
    else $error("total area on a non-last item");

    // A stored rectangle is never empty and never larger than the screen limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !list_empty |-> out_w != '0 && out_h != '0 &&
            out_w <= DIM_MAX && out_h <= DIM_MAX)
    else $error("bad rectangle size");

    // While a flush is still streaming, no new item is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_last |-> !in_ready)
    else $error("input ready during a flush");

    // A stalled result item stays valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

endmodule

bind dirty_rect_coalescer_top drc_prop_checker u_drc_prop_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_x      (out_ch.out_x),
    .out_y      (out_ch.out_y),
    .out_w      (out_ch.out_w),
    .out_h      (out_ch.out_h),
    .total_area (out_ch.total_area),
    .is_last    (out_ch.is_last),
    .list_empty (out_ch.list_empty)
);
